>>> sv/hafr_pkg.sv
// Shared types and constants for the handle allocator with FIFO reuse.
// Used by hafr_front, hafr_cmd_queue, hafr_back and the top level.
// No dependencies.
package hafr_pkg;

  localparam int HANDLE_W            = 10;
  localparam int TABLE_DEPTH         = 1 << HANDLE_W;
  localparam int FRESH_W             = HANDLE_W + 1;
  localparam int DEFAULT_MAX_HANDLES = 1024;
  localparam int STREAM_W            = 16;

  // Depth of the queue between front and back; must be a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    FN_ALLOC_ARRAY  = 3'd0,
    FN_ALLOC_STRING = 3'd1,
    FN_COPY         = 3'd2,
    FN_DESTROY      = 3'd3,
    FN_CHECK_ARRAY  = 3'd4,
    FN_CHECK_STRING = 3'd5,
    FN_EXISTS       = 3'd6,
    FN_CLEAR        = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NULL       = 3'd1,
    ST_NO_OBJECT  = 3'd2,
    ST_WRONG_TYPE = 3'd3,
    ST_EXHAUSTED  = 3'd4
  } status_t;

  // Operation class produced by the front end.
  typedef enum logic [2:0] {
    CL_ALLOC,
    CL_COPY,
    CL_DESTROY,
    CL_CHECK,
    CL_EXISTS,
    CL_CLEAR
  } op_class_t;

  // Decoded command. kind is the requested kind for an allocation and the
  // expected kind for a check.
  typedef struct packed {
    op_class_t             cls;
    logic                  kind;
    logic [HANDLE_W-1:0]   handle;
  } cmd_t;

  // Result item; handle_out sits in the lowest bits.
  typedef struct packed {
    logic                  kind_out;
    logic                  present;
    status_t               status;
    logic [HANDLE_W-1:0]   handle_out;
  } res_t;

endpackage

>>> sv/handle_allocator_fifo_reuse.sv
// Top level of the handle allocator with FIFO reuse of freed handles.
// Depends on hafr_pkg, hafr_front, hafr_cmd_queue and hafr_back.
//
//   Channel   Direction  Signals                  Payload
//   s_axis    in         tvalid, tready, tdata    command: func, handle_in
//   m_axis    out        tvalid, tready, tdata    result: handle_out, status,
//                                                 present, kind_out
//
// In the back end, B_READ reads the handle table and the head of the free FIFO for
// a command, then B_EXEC decides, writes both memories and loads the result
// register. A new command is read only after B_EXEC has finished the last one.
// After reset, and after every clear command, all 1024 table entries are swept one
// entry a cycle; s_axis_tready stays low meanwhile.
// A result waiting in the output register stalls only the back end; the
// front end keeps filling the two-entry command queue.
module handle_allocator_fifo_reuse #(
  // Handles run from 1 up to the smaller of MAX_HANDLES and 1024, minus one.
  parameter int MAX_HANDLES = hafr_pkg::DEFAULT_MAX_HANDLES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [2:0] func, [12:3] handle_in, [15:13] zero
  input  logic [hafr_pkg::STREAM_W-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [9:0] handle_out, [12:10] status, [13] present, [14] kind_out, [15] zero
  output logic [hafr_pkg::STREAM_W-1:0] m_axis_tdata
);
  import hafr_pkg::*;

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_not_empty;
  logic  clearing;
  cmd_t  push_cmd;
  cmd_t  head_cmd;
  res_t  res;

  // The front end classifies each transfer and hands it to the queue.
  hafr_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full        (q_full),
    .clearing      (clearing),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  // The queue decouples acceptance from execution.
  hafr_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  // The back end owns the table, the free FIFO, the counters and the result register.
  hafr_back #(
    .MAX_HANDLES (MAX_HANDLES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_cmd       (head_cmd),
    .q_pop       (q_pop),
    .clearing    (clearing),
    .res_valid   (m_axis_tvalid),
    .res_ready   (m_axis_tready),
    .res         (res)
  );

  // Result fields are packed with handle_out in the lowest bits.
  assign m_axis_tdata = {{(STREAM_W - $bits(res_t)){1'b0}}, res};

endmodule

>>> sv/hafr_front.sv
// Front end: accepts input transfers and classifies them into commands.
// Depends on hafr_pkg.
module hafr_front (
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [hafr_pkg::STREAM_W-1:0]   s_axis_tdata,
  input  logic                            q_full,
  input  logic                            clearing,
  output logic                            q_push,
  output hafr_pkg::cmd_t                  q_cmd
);
  import hafr_pkg::*;

  func_t func;

  assign func          = func_t'(s_axis_tdata[2:0]);
  assign s_axis_tready = !q_full && !clearing;
  assign q_push        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    q_cmd.handle = s_axis_tdata[3 +: HANDLE_W];
    // Both allocations and both checks carry the kind in the low func bit.
    q_cmd.kind   = s_axis_tdata[0];
    case (func)
      FN_ALLOC_ARRAY, FN_ALLOC_STRING: q_cmd.cls = CL_ALLOC;
      FN_COPY:                         q_cmd.cls = CL_COPY;
      FN_DESTROY:                      q_cmd.cls = CL_DESTROY;
      FN_CHECK_ARRAY, FN_CHECK_STRING: q_cmd.cls = CL_CHECK;
      FN_EXISTS:                       q_cmd.cls = CL_EXISTS;
      FN_CLEAR:                        q_cmd.cls = CL_CLEAR;
      default:                         q_cmd.cls = CL_EXISTS;
    endcase
  end

endmodule

>>> sv/hafr_cmd_queue.sv
// Short command queue between the front end and the back end.
// Depends on hafr_pkg.
module hafr_cmd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hafr_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output hafr_pkg::cmd_t  head_cmd
);
  import hafr_pkg::*;

  cmd_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head_cmd  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end
  end

endmodule

>>> sv/hafr_back.sv
// Back end: handle table and free FIFO memories, allocation counters,
// clearing sweep and the result register. Depends on hafr_pkg.
module hafr_back #(
  parameter int MAX_HANDLES = hafr_pkg::DEFAULT_MAX_HANDLES
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_not_empty,
  input  hafr_pkg::cmd_t  q_cmd,
  output logic            q_pop,
  output logic            clearing,
  output logic            res_valid,
  input  logic            res_ready,
  output hafr_pkg::res_t  res
);
  import hafr_pkg::*;

  localparam int HandleLimit = (MAX_HANDLES < TABLE_DEPTH) ? MAX_HANDLES : TABLE_DEPTH;
  localparam logic [FRESH_W-1:0] FreshLimit = FRESH_W'(HandleLimit);

  typedef enum logic [1:0] {
    B_SWEEP,
    B_READ,
    B_EXEC
  } state_t;

  state_t                state;
  logic [HANDLE_W-1:0]   sweep_idx;
  cmd_t                  cur;
  logic [HANDLE_W-1:0]   fifo_head;
  logic [FRESH_W-1:0]    fifo_count;
  logic [FRESH_W-1:0]    next_fresh;

  // Each table entry holds {live, kind}.
  logic [1:0]            tbl_mem  [TABLE_DEPTH];
  logic [HANDLE_W-1:0]   fifo_mem [TABLE_DEPTH];
  logic [1:0]            tbl_q;
  logic [HANDLE_W-1:0]   fifo_q;

  logic                  rd_en;
  logic                  exec_fire;
  logic                  live;
  logic                  kind;
  logic                  fifo_avail;
  logic                  fresh_avail;
  logic                  do_alloc;
  logic                  do_free;
  logic                  do_clear;
  logic                  alloc_kind;
  logic                  got;
  logic [HANDLE_W-1:0]   new_h;
  status_t               status;

  logic                  tbl_we;
  logic [HANDLE_W-1:0]   tbl_wa;
  logic [1:0]            tbl_wd;
  logic [HANDLE_W-1:0]   fifo_tail;

  assign clearing    = (state == B_SWEEP);
  assign rd_en       = (state == B_READ) && q_not_empty;
  assign q_pop       = rd_en;
  assign exec_fire   = (state == B_EXEC) && (!res_valid || res_ready);

  assign live        = (cur.handle != '0) && tbl_q[1];
  assign kind        = live && tbl_q[0];
  assign fifo_avail  = (fifo_count != '0);
  assign fresh_avail = (next_fresh < FreshLimit);
  assign got         = fifo_avail || fresh_avail;
  assign fifo_tail   = fifo_head + fifo_count[HANDLE_W-1:0];

  always_comb begin
    do_alloc   = 1'b0;
    do_free    = 1'b0;
    do_clear   = 1'b0;
    alloc_kind = cur.kind;
    status     = ST_OK;
    case (cur.cls)
      CL_ALLOC: begin
        do_alloc = 1'b1;
      end
      CL_COPY: begin
        // The source is checked before a handle is taken.
        if (cur.handle == '0) begin
          status = ST_NULL;
        end else if (!live) begin
          status = ST_NO_OBJECT;
        end else begin
          do_alloc   = 1'b1;
          alloc_kind = kind;
        end
      end
      CL_DESTROY: begin
        if (!live) begin
          status = ST_NO_OBJECT;
        end else begin
          do_free = 1'b1;
        end
      end
      CL_CHECK: begin
        if (cur.handle == '0) begin
          status = ST_NULL;
        end else if (!live) begin
          status = ST_NO_OBJECT;
        end else if (kind != cur.kind) begin
          status = ST_WRONG_TYPE;
        end
      end
      CL_EXISTS: begin
        status = ST_OK;
      end
      CL_CLEAR: begin
        do_clear = 1'b1;
      end
      default: begin
        status = ST_OK;
      end
    endcase

    // Freed handles are reused oldest first, then the fresh counter.
    if (fifo_avail) begin
      new_h = fifo_q;
    end else if (fresh_avail) begin
      new_h = next_fresh[HANDLE_W-1:0];
    end else begin
      new_h = '0;
    end
    if (!do_alloc || !got) begin
      new_h = '0;
    end
    if (do_alloc && !got) begin
      status = ST_EXHAUSTED;
    end
  end

  // Table write port: the sweep clears one entry a cycle; an item writes at
  // most one entry.
  always_comb begin
    tbl_we = 1'b0;
    tbl_wa = cur.handle;
    tbl_wd = 2'b00;
    if (state == B_SWEEP) begin
      tbl_we = 1'b1;
      tbl_wa = sweep_idx;
    end else if (exec_fire && do_alloc && got) begin
      tbl_we = 1'b1;
      tbl_wa = new_h;
      tbl_wd = {1'b1, alloc_kind};
    end else if (exec_fire && do_free) begin
      tbl_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    if (rd_en) begin
      tbl_q <= tbl_mem[q_cmd.handle];
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire && do_free) begin
      fifo_mem[fifo_tail] <= cur.handle;
    end
    if (rd_en) begin
      fifo_q <= fifo_mem[fifo_head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_SWEEP;
      sweep_idx  <= '0;
      fifo_head  <= '0;
      fifo_count <= '0;
      next_fresh <= FRESH_W'(1);
      res_valid  <= 1'b0;
    end else begin
      if (res_valid && res_ready && !exec_fire) begin
        res_valid <= 1'b0;
      end
      case (state)
        B_SWEEP: begin
          sweep_idx <= sweep_idx + 1'b1;
          if (sweep_idx == HANDLE_W'(TABLE_DEPTH - 1)) begin
            state <= B_READ;
          end
        end
        B_READ: begin
          if (rd_en) begin
            cur   <= q_cmd;
            state <= B_EXEC;
          end
        end
        B_EXEC: begin
          if (exec_fire) begin
            res_valid      <= 1'b1;
            res.handle_out <= new_h;
            res.status     <= status;
            res.present    <= live;
            res.kind_out   <= kind;
            state          <= do_clear ? B_SWEEP : B_READ;
            if (do_alloc && fifo_avail) begin
              fifo_head  <= fifo_head + 1'b1;
              fifo_count <= fifo_count - FRESH_W'(1);
            end else if (do_alloc && fresh_avail) begin
              next_fresh <= next_fresh + FRESH_W'(1);
            end
            if (do_free) begin
              fifo_count <= fifo_count + FRESH_W'(1);
            end
            if (do_clear) begin
              fifo_head  <= '0;
              fifo_count <= '0;
              next_fresh <= FRESH_W'(1);
              sweep_idx  <= '0;
            end
          end
        end
        default: begin
          state <= B_READ;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count < FRESH_W'(TABLE_DEPTH))
    else $error("free FIFO holds more handles than the table has");

  a_fresh_range: assert property (@(posedge clk) disable iff (rst)
    (next_fresh != '0) && (next_fresh <= FreshLimit))
    else $error("fresh counter left its range");

  a_clear_sweep: assert property (@(posedge clk) disable iff (rst)
    exec_fire && do_clear |=> (state == B_SWEEP) && (sweep_idx == '0))
    else $error("clear did not start a sweep from entry zero");

  a_exhausted_null: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status == ST_EXHAUSTED) |-> (res.handle_out == '0))
    else $error("exhausted allocation returned a handle");
`endif

endmodule
